>>> sv/h2r_pkg.sv
`timescale 1ns / 1ps

package h2r_pkg;

   // Default fraction bits of saturation and lightness, and the queue depth.
   localparam int H2R_FRAC_BITS   = 12;
   localparam int H2R_QUEUE_DEPTH = 4;

   // Hue breakpoints in degrees.
   localparam int HUE_RAMP       = 60;
   localparam int HUE_THIRD      = 120;
   localparam int HUE_HALF       = 180;
   localparam int HUE_TWO_THIRDS = 240;
   localparam int HUE_FULL       = 360;

   localparam int BYTE_MAX = 255;

   // Channel slots in the weight vector.
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;
   localparam int CH_COUNT = 3;

   // One classified pixel as it sits in the queue between front and back.
   typedef struct packed {
      logic [CH_COUNT-1:0][5:0] weight;
      logic                     gray;
      logic [12:0]              saturation;
      logic [12:0]              lightness;
      logic [7:0]               alpha;
   } h2r_item_type;

   // Folds a shifted hue back into 0 to 360 degrees; one fold is enough.
   function automatic logic [8:0] wrap_hue(input logic signed [10:0] t);
      logic signed [10:0] w;
      w = t;
      if (w < 0) begin
         w = w + 11'(HUE_FULL);
      end
      if (w > 11'(HUE_FULL)) begin
         w = w - 11'(HUE_FULL);
      end
      return w[8:0];
   endfunction

   // Weight of v2 - v1 in the channel value, 0 to 60, for a wrapped hue.
   function automatic logic [5:0] hue_weight(input logic [8:0] t);
      logic [5:0] w;
      if (t < 9'(HUE_RAMP)) begin
         w = t[5:0];
      end else if (t < 9'(HUE_HALF)) begin
         w = 6'(HUE_RAMP);
      end else if (t < 9'(HUE_TWO_THIRDS)) begin
         w = 6'(9'(HUE_TWO_THIRDS) - t);
      end else begin
         w = '0;
      end
      return w;
   endfunction

endpackage

>>> sv/h2r_if.sv
`timescale 1ns / 1ps

// Channel that carries one HSL pixel.
interface h2r_req_if;
   logic        valid;
   logic        ready;
   logic [8:0]  hue_degrees;
   logic [12:0] saturation;
   logic [12:0] lightness;
   logic [7:0]  alpha_in;

   modport source (output valid, output hue_degrees, output saturation,
                   output lightness, output alpha_in, input ready);
   modport sink   (input valid, input hue_degrees, input saturation,
                   input lightness, input alpha_in, output ready);
endinterface

// Channel that carries one RGB pixel.
interface h2r_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha_out;

   modport source (output valid, output red, output green, output blue,
                   output alpha_out, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input alpha_out, output ready);
endinterface

>>> sv/h2r_front.sv
`timescale 1ns / 1ps

module h2r_front
   import h2r_pkg::*;
(
   h2r_req_if.sink      req,
   input  logic         q_full,
   output logic         q_push,
   output h2r_item_type q_item
);

   logic signed [10:0] hue_s;
   logic [8:0]         t_red;
   logic [8:0]         t_green;
   logic [8:0]         t_blue;

   // A transfer is taken whenever the queue has room.
   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   // Hue shifted by plus and minus a third of a turn, wrapped into range.
   assign hue_s   = $signed({2'b00, req.hue_degrees});
   assign t_red   = wrap_hue(hue_s + 11'(HUE_THIRD));
   assign t_green = wrap_hue(hue_s);
   assign t_blue  = wrap_hue(hue_s - 11'(HUE_THIRD));

   // Classify: gray when saturation is zero, else one ramp weight per channel.
   always_comb begin
      q_item.weight[CH_RED]   = hue_weight(t_red);
      q_item.weight[CH_GREEN] = hue_weight(t_green);
      q_item.weight[CH_BLUE]  = hue_weight(t_blue);
      q_item.gray             = (req.saturation == '0);
      q_item.saturation       = req.saturation;
      q_item.lightness        = req.lightness;
      q_item.alpha            = req.alpha_in;
   end

endmodule

>>> sv/h2r_queue.sv
`timescale 1ns / 1ps

module h2r_queue
   import h2r_pkg::*;
#(
   parameter int DEPTH = H2R_QUEUE_DEPTH
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  h2r_item_type push_item,
   output logic         full,
   input  logic         pop,
   output h2r_item_type pop_item,
   output logic         empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   h2r_item_type   entry_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff;
   logic [PW-1:0]  wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff;
   logic [PW-1:0]  rd_ptr_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates, with wrap at the last entry.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset; the fill count guards every read.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> sv/h2r_back.sv
`timescale 1ns / 1ps

module h2r_back
   import h2r_pkg::*;
#(
   parameter int FRAC_BITS = H2R_FRAC_BITS
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   input  h2r_item_type q_item,
   output logic         q_pop,
   h2r_rsp_if.source    rsp
);

   // v1, v2 in units of 2^-2F; channel values in units of 2^-2F / 60.
   localparam int VW   = ((FRAC_BITS > 12) ? FRAC_BITS : 12) + 19;
   localparam int CW   = VW + 8;
   localparam int NW   = CW + 6;
   localparam int QLSB = 2 * FRAC_BITS + 2;
   localparam int GPW  = (FRAC_BITS + 9 > 21) ? FRAC_BITS + 9 : 21;

   logic advance;

   // Stage 1: saturation times lightness.
   logic                      s1_valid_ff;
   h2r_item_type              s1_item_ff;
   logic [25:0]               s1_prod_ff;
   logic [25:0]               s1_prod_in;

   // Stage 2: v1, the difference v2 - v1, and the gray byte.
   logic                      s2_valid_ff;
   logic                      s2_gray_ff;
   logic [7:0]                s2_gray_byte_ff;
   logic [7:0]                s2_gray_byte_in;
   logic signed [VW-1:0]      s2_v1_ff;
   logic signed [VW-1:0]      s2_v1_in;
   logic signed [VW-1:0]      s2_diff_ff;
   logic signed [VW-1:0]      s2_diff_in;
   logic [CH_COUNT-1:0][5:0]  s2_weight_ff;
   logic [7:0]                s2_alpha_ff;

   // Stage 3: channel values before scaling.
   logic                      s3_valid_ff;
   logic                      s3_gray_ff;
   logic [7:0]                s3_gray_byte_ff;
   logic signed [CW-1:0]      s3_chan_ff [CH_COUNT];
   logic signed [CW-1:0]      s3_chan_in [CH_COUNT];
   logic [7:0]                s3_alpha_ff;

   // Stage 4: the output register.
   logic                      s4_valid_ff;
   logic [7:0]                s4_byte_ff [CH_COUNT];
   logic [7:0]                s4_byte_in [CH_COUNT];
   logic [7:0]                s4_alpha_ff;

   logic signed [VW-1:0]      l_ext;
   logic signed [VW-1:0]      s_ext;
   logic signed [VW-1:0]      prod_ext;
   logic signed [VW-1:0]      v2;
   logic [GPW-1:0]            gray_prod;
   logic [GPW-1:0]            gray_shift;
   logic signed [NW-1:0]      scaled [CH_COUNT];

   function automatic logic [25:0] s1_item_prod(input h2r_item_type it);
      return it.lightness * it.saturation;
   endfunction

   // The whole back end holds while the output register waits.
   assign advance = !s4_valid_ff || rsp.ready;
   assign q_pop   = advance && !q_empty;

   assign s1_prod_in = 26'(s1_item_prod(q_item));

   // Two-value method: v2 depends on which half lightness lies in.
   always_comb begin
      l_ext    = VW'(s1_item_ff.lightness);
      s_ext    = VW'(s1_item_ff.saturation);
      prod_ext = VW'(s1_prod_ff);
      if ((l_ext <<< 1) < (VW'(1) <<< FRAC_BITS)) begin
         v2 = (l_ext <<< FRAC_BITS) + prod_ext;
      end else begin
         v2 = ((l_ext + s_ext) <<< FRAC_BITS) - prod_ext;
      end
      s2_v1_in   = (l_ext <<< (FRAC_BITS + 1)) - v2;
      s2_diff_in = v2 - s2_v1_in;
   end

   // Gray level: lightness times 255, truncated, saturated.
   always_comb begin
      gray_prod  = (GPW'(s1_item_ff.lightness) << 8) - GPW'(s1_item_ff.lightness);
      gray_shift = gray_prod >> FRAC_BITS;
      s2_gray_byte_in = (gray_shift > GPW'(BYTE_MAX)) ? 8'(BYTE_MAX) : gray_shift[7:0];
   end

   // Channel value: 60 * v1 + weight * (v2 - v1), one multiplier per channel.
   always_comb begin
      for (int k = 0; k < CH_COUNT; k++) begin
         s3_chan_in[k] = (CW'(s2_v1_ff) <<< 6) - (CW'(s2_v1_ff) <<< 2)
                       + s2_diff_ff * $signed({1'b0, s2_weight_ff[k]});
      end
   end

   // Scale by 255 and round half up: floor((17c + 2^(2F+1)) / 2^(2F+2)).
   always_comb begin
      for (int k = 0; k < CH_COUNT; k++) begin
         scaled[k] = (NW'(s3_chan_ff[k]) <<< 4) + NW'(s3_chan_ff[k])
                   + (NW'(1) <<< (2 * FRAC_BITS + 1));
         if (s3_gray_ff) begin
            s4_byte_in[k] = s3_gray_byte_ff;
         end else if (scaled[k][NW-1]) begin
            s4_byte_in[k] = '0;
         end else if (|scaled[k][NW-2:QLSB+8]) begin
            s4_byte_in[k] = 8'(BYTE_MAX);
         end else begin
            s4_byte_in[k] = scaled[k][QLSB+7:QLSB];
         end
      end
   end

   // Valid bits of the four stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= !q_empty;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Payload registers of the four stages.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff      <= q_item;
         s1_prod_ff      <= s1_prod_in;
         s2_gray_ff      <= s1_item_ff.gray;
         s2_gray_byte_ff <= s2_gray_byte_in;
         s2_v1_ff        <= s2_v1_in;
         s2_diff_ff      <= s2_diff_in;
         s2_weight_ff    <= s1_item_ff.weight;
         s2_alpha_ff     <= s1_item_ff.alpha;
         s3_gray_ff      <= s2_gray_ff;
         s3_gray_byte_ff <= s2_gray_byte_ff;
         s3_chan_ff      <= s3_chan_in;
         s3_alpha_ff     <= s2_alpha_ff;
         s4_byte_ff      <= s4_byte_in;
         s4_alpha_ff     <= s3_alpha_ff;
      end
   end

   assign rsp.valid     = s4_valid_ff;
   assign rsp.red       = s4_byte_ff[CH_RED];
   assign rsp.green     = s4_byte_ff[CH_GREEN];
   assign rsp.blue      = s4_byte_ff[CH_BLUE];
   assign rsp.alpha_out = s4_alpha_ff;

endmodule

>>> sv/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps

// Channel   Role     Payload
// req_ch    sink     hue_degrees[8:0], saturation[12:0], lightness[12:0], alpha_in[7:0]
// rsp_ch    source   red[7:0], green[7:0], blue[7:0], alpha_out[7:0]
//
// One pixel per cycle in and out while rsp_ch does not stall. A pixel that meets an
// empty queue is written into the queue and then passes the four register stages of
// the arithmetic back end (multiply, two-value step, channel multiply, scaling) before
// it appears on rsp_ch. Reset is synchronous and clears the queue pointers, the fill
// count and the stage valid bits. A stall on rsp_ch freezes the back end; the queue keeps
// taking pixels until it holds QUEUE_DEPTH of them, and only then does req_ch.ready drop.

module hsl_to_rgb_converter
   import h2r_pkg::*;
#(
   parameter int FRAC_BITS   = H2R_FRAC_BITS,
   parameter int QUEUE_DEPTH = H2R_QUEUE_DEPTH
)
(
   input logic       clock,
   input logic       reset,
   h2r_req_if.sink   req_ch,
   h2r_rsp_if.source rsp_ch
);

   logic         q_push;
   logic         q_full;
   logic         q_pop;
   logic         q_empty;
   h2r_item_type q_push_item;
   h2r_item_type q_pop_item;

   // Front end: accept and classify.
   h2r_front u_front (
      .req    (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_item (q_push_item)
   );

   // Queue between front and back.
   h2r_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .empty     (q_empty)
   );

   // Back end: arithmetic pipeline and output register.
   h2r_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_item  (q_pop_item),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

   // A queue write happens exactly on an input transfer.
   a_push_is_transfer: assert property (@(posedge clock) disable iff (reset)
      q_push == (req_ch.valid && req_ch.ready))
      else $error("queue write does not match input transfer");

   // The queue is never written while full.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("queue written while full");

   // The queue is never read while empty.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("queue read while empty");

endmodule

>>> dv/hsl_to_rgb_checker.sv
`timescale 1ns / 1ps

// Watches both pixel channels, predicts the RGB pixel for every accepted HSL
// pixel and compares each returned pixel with the oldest prediction.
module hsl_to_rgb_checker
   import h2r_pkg::*;
(
   input  logic clock,
   input  logic reset,
   h2r_req_if   req_mon,
   h2r_rsp_if   rsp_mon,
   output int   error_count,
   output int   pending_count,
   output int   pixels_in,
   output int   pixels_out
);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgb_pixel_type;

   // Predicted pixels, oldest first.
   rgb_pixel_type expected_rgb[$];

   int errors   = 0;
   int accepted = 0;
   int produced = 0;

   // Channel value in units of 1/(60*S^2) for a hue offset t in degrees.
   function automatic longint channel_level(input longint v1, input longint v2,
                                            input longint t);
      longint w;
      w = t;
      if (w < 0) begin
         w = w + HUE_FULL;
      end
      if (w > HUE_FULL) begin
         w = w - HUE_FULL;
      end
      if (w < HUE_RAMP) begin
         return v1 * HUE_RAMP + (v2 - v1) * w;
      end
      if (w < HUE_HALF) begin
         return v2 * HUE_RAMP;
      end
      if (w < HUE_TWO_THIRDS) begin
         return v1 * HUE_RAMP + (v2 - v1) * (HUE_TWO_THIRDS - w);
      end
      return v1 * HUE_RAMP;
   endfunction

   // Scales a channel level to a byte, rounding half up and clamping.
   function automatic logic [7:0] channel_byte(input longint level, input longint den);
      longint num;
      longint q;
      num = 2 * BYTE_MAX * level + den;
      if (num < 0) begin
         return 8'd0;
      end
      q = num / (2 * den);
      if (q > BYTE_MAX) begin
         q = BYTE_MAX;
      end
      return q[7:0];
   endfunction

   // Full conversion of one HSL pixel.
   function automatic rgb_pixel_type predict_rgb(input logic [8:0] hue,
                                                 input logic [12:0] sat,
                                                 input logic [12:0] lit,
                                                 input logic [7:0] alpha);
      longint scale;
      longint h;
      longint s;
      longint l;
      longint v1;
      longint v2;
      longint den;
      longint gray;
      rgb_pixel_type px;
      scale    = longint'(1) << H2R_FRAC_BITS;
      h        = longint'(hue);
      s        = longint'(sat);
      l        = longint'(lit);
      px.alpha = alpha;
      if (s == 0) begin
         // Gray is truncated, not rounded.
         gray = (l * BYTE_MAX) / scale;
         if (gray > BYTE_MAX) begin
            gray = BYTE_MAX;
         end
         px.red   = gray[7:0];
         px.green = gray[7:0];
         px.blue  = gray[7:0];
      end else begin
         den = scale * scale * HUE_RAMP;
         if (2 * l < scale) begin
            v2 = l * (scale + s);
         end else begin
            v2 = (l + s) * scale - l * s;
         end
         v1       = 2 * l * scale - v2;
         px.red   = channel_byte(channel_level(v1, v2, h + HUE_THIRD), den);
         px.green = channel_byte(channel_level(v1, v2, h), den);
         px.blue  = channel_byte(channel_level(v1, v2, h - HUE_THIRD), den);
      end
      return px;
   endfunction

   function automatic int check_channel(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Results are checked before new predictions are queued, since a pixel
   // never comes out at the edge of its own transfer.
   always @(posedge clock) begin : monitor
      rgb_pixel_type want;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            produced++;
            if (expected_rgb.size() == 0) begin
               $display("%0t: result with none expected, actual r=%0d g=%0d b=%0d a=%0d",
                        $time, rsp_mon.red, rsp_mon.green, rsp_mon.blue,
                        rsp_mon.alpha_out);
               errors++;
            end else begin
               want   = expected_rgb.pop_front();
               errors += check_channel("red", want.red, rsp_mon.red);
               errors += check_channel("green", want.green, rsp_mon.green);
               errors += check_channel("blue", want.blue, rsp_mon.blue);
               errors += check_channel("alpha", want.alpha, rsp_mon.alpha_out);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            accepted++;
            expected_rgb.push_back(predict_rgb(req_mon.hue_degrees, req_mon.saturation,
                                               req_mon.lightness, req_mon.alpha_in));
         end
      end
      error_count   <= errors;
      pending_count <= expected_rgb.size();
      pixels_in     <= accepted;
      pixels_out    <= produced;
   end

endmodule

>>> dv/tb_hsl_to_rgb_converter.sv
`timescale 1ns / 1ps

module tb_hsl_to_rgb_converter
   import h2r_pkg::*;
();

   localparam int RANDOM_PIXELS = 1380;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_CYCLES  = 16;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int IDLE_PERCENT  = 11;
   localparam logic [12:0] ONE  = 13'(1 << H2R_FRAC_BITS);
   localparam logic [12:0] HALF = 13'(1 << (H2R_FRAC_BITS - 1));

   logic clock;
   logic reset;

   h2r_req_if req_ch ();
   h2r_rsp_if rsp_ch ();

   int  error_count;
   int  pending_count;
   int  pixels_in;
   int  pixels_out;
   int  cycle_count;
   int  hold_count  = 0;
   bit  steady      = 1'b0;
   bit  hold_output = 1'b0;

   hsl_to_rgb_converter i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   hsl_to_rgb_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .error_count   (error_count),
      .pending_count (pending_count),
      .pixels_in     (pixels_in),
      .pixels_out    (pixels_out)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offers one pixel, after a random idle gap, and waits for its transfer.
   // Valid stays high between back-to-back pixels.
   task automatic send_pixel(input logic [8:0] hue, input logic [12:0] sat,
                             input logic [12:0] lit, input logic [7:0] alpha);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.hue_degrees <= hue;
      req_ch.saturation  <= sat;
      req_ch.lightness   <= lit;
      req_ch.alpha_in    <= alpha;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   // Mostly in-range colors, some grays, and some raw bit patterns that
   // reach hue above 360 and saturation or lightness above 1.0.
   task automatic send_random_pixel();
      int kind;
      kind = $urandom_range(99);
      if (kind < 70) begin
         send_pixel(9'($urandom_range(HUE_FULL)), 13'($urandom_range(ONE)),
                    13'($urandom_range(ONE)), 8'($urandom));
      end else if (kind < 80) begin
         send_pixel(9'($urandom), 13'd0, 13'($urandom), 8'($urandom));
      end else begin
         send_pixel(9'($urandom), 13'($urandom), 13'($urandom), 8'($urandom));
      end
   endtask

   // Result side: random stalls, or one long hold-off when asked for.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         if (hold_output) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_output = 1'b0;
            hold_count++;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            @(posedge clock);
         end
      end
   end

   // Run limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.hue_degrees <= '0;
      req_ch.saturation  <= '0;
      req_ch.lightness   <= '0;
      req_ch.alpha_in    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Grays: black, white, above full scale, and truncation.
      send_pixel(9'd0, 13'd0, 13'd0, 8'd0);
      send_pixel(9'd0, 13'd0, ONE, 8'd255);
      send_pixel(9'd0, 13'd0, 13'h1FFF, 8'd17);
      send_pixel(9'd0, 13'd0, 13'd2049, 8'd1);

      // Fully saturated colors at every hue breakpoint, lightness at one half.
      send_pixel(9'd0, ONE, HALF, 8'd2);
      send_pixel(9'(HUE_RAMP), ONE, HALF, 8'd3);
      send_pixel(9'(HUE_THIRD), ONE, HALF, 8'd4);
      send_pixel(9'(HUE_HALF), ONE, HALF, 8'd5);
      send_pixel(9'(HUE_TWO_THIRDS), ONE, HALF, 8'd6);
      send_pixel(9'd300, ONE, HALF, 8'd7);
      send_pixel(9'd359, ONE, HALF, 8'd8);
      send_pixel(9'(HUE_FULL), ONE, HALF, 8'd9);

      // Hue beyond a full turn.
      send_pixel(9'd361, ONE, HALF, 8'd10);
      send_pixel(9'h1FF, 13'h1FFF, 13'h1FFF, 8'hFF);

      // Lightness just below one half, saturation and lightness above 1.0, and tiny or zero values.
      send_pixel(9'd30, ONE, HALF - 13'd1, 8'h55);
      send_pixel(9'd200, 13'h1FFF, 13'd1000, 8'hAA);
      send_pixel(9'd150, 13'd2048, 13'h1FFF, 8'h0F);
      send_pixel(9'd90, 13'd1, ONE, 8'hF0);
      send_pixel(9'd270, ONE, 13'd0, 8'h80);
      send_pixel(9'h0AA, 13'd1, 13'd1, 8'h7F);
      send_pixel(9'h155, 13'h0AAA, 13'h1555, 8'h33);

      // Random pixels: idling on both sides, then a stretch with none, then idling again
      // and a long hold-off on the result side while pixels keep coming.
      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         if (n == 400) begin
            steady = 1'b1;
         end else if (n == 700) begin
            steady = 1'b0;
         end else if (n == 800) begin
            hold_output = 1'b1;
         end
         send_random_pixel();
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d pixels (%0d returned): grays, all hue breakpoints,",
               pixels_in, pixels_out);
      $display("hue past 360, over-range inputs, %0d long output hold-off(s).", hold_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/h2r_pkg.sv
sv/h2r_if.sv
sv/h2r_front.sv
sv/h2r_queue.sv
sv/h2r_back.sv
sv/hsl_to_rgb_converter.sv
dv/hsl_to_rgb_checker.sv
dv/tb_hsl_to_rgb_converter.sv
